// ----- sv/lrp_pkg.sv -----
// ----------------------------------------------------------------------------
// lrp_pkg
// Shared types and codes of the link reconnect policy block.
// ----------------------------------------------------------------------------
package lrp_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [7:0] SAT_MAX = 8'd255;

  localparam logic [1:0] CMD_STEP  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_TAKE  = 2'd2;

  localparam logic [2:0] ACT_NONE          = 3'd0;
  localparam logic [2:0] ACT_STOP_AP       = 3'd1;
  localparam logic [2:0] ACT_START_AP      = 3'd2;
  localparam logic [2:0] ACT_REBOOT        = 3'd3;
  localparam logic [2:0] ACT_RESTART_RADIO = 3'd4;
  localparam logic [2:0] ACT_FAST          = 3'd5;
  localparam logic [2:0] ACT_SCAN          = 3'd6;

  localparam logic [2:0] REG_CONNECT_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_FORGET_FAST     = 3'd1;
  localparam logic [2:0] REG_RESTART_RADIO   = 3'd2;
  localparam logic [2:0] REG_AP_RETRY        = 3'd3;
  localparam logic [2:0] REG_REBOOT_AFTER    = 3'd4;
  localparam logic [2:0] REG_AP_AFTER        = 3'd5;

  typedef struct packed {
    logic [31:0] connect_timeout_ms;
    logic [7:0]  forget_fast_after;
    logic [7:0]  restart_radio_every;
    logic [31:0] ap_retry_ms;
    logic [31:0] reboot_after_ms;
    logic [31:0] ap_after_ms;
  } cfg_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } mod_status_t;

endpackage

// ----- sv/lrp_alu.sv -----
// ----------------------------------------------------------------------------
// lrp_alu
// Shared subtractor: wrapping difference and unsigned compare by borrow.
// ----------------------------------------------------------------------------
module lrp_alu #(
  parameter int Width = 32
) (
  input  logic [Width-1:0] a_i,
  input  logic [Width-1:0] b_i,
  output logic [Width-1:0] diff_o,
  output logic             borrow_o
);

  logic [Width:0] full;

  assign full     = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o   = full[Width-1:0];
  assign borrow_o = full[Width];

endmodule

// ----- sv/lrp_mod.sv -----
// ----------------------------------------------------------------------------
// lrp_mod
// Restoring remainder of two 8-bit values, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrp_mod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [7:0]           dividend_i,
  input  logic [7:0]           divisor_i,
  output lrp_pkg::mod_status_t status_o
);

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [2:0] cnt_q, cnt_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] dvd_q, dvd_d;
  logic [7:0] dvs_q, dvs_d;
  logic [8:0] trial;

  always_comb begin
    trial  = {rem_q, dvd_q[7]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd0;
      rem_d  = 8'd0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 8'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[7:0];
      end
      dvd_d = {dvd_q[6:0], 1'b0};
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign status_o.done     = done_q;
  assign status_o.rem_zero = (rem_q == 8'd0);

endmodule

// ----- sv/lrp_cfg.sv -----
// ----------------------------------------------------------------------------
// lrp_cfg
// APB register file holding the policy thresholds.
// ----------------------------------------------------------------------------
module lrp_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lrp_pkg::ADDR_W-1:0]  paddr,
  input  logic [lrp_pkg::DATA_W-1:0]  pwdata,
  output logic [lrp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output lrp_pkg::cfg_t               cfg_o
);

  lrp_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        lrp_pkg::REG_CONNECT_TIMEOUT: cfg_d.connect_timeout_ms  = pwdata;
        lrp_pkg::REG_FORGET_FAST:     cfg_d.forget_fast_after   = pwdata[7:0];
        lrp_pkg::REG_RESTART_RADIO:   cfg_d.restart_radio_every = pwdata[7:0];
        lrp_pkg::REG_AP_RETRY:        cfg_d.ap_retry_ms         = pwdata;
        lrp_pkg::REG_REBOOT_AFTER:    cfg_d.reboot_after_ms     = pwdata;
        lrp_pkg::REG_AP_AFTER:        cfg_d.ap_after_ms         = pwdata;
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lrp_pkg::REG_CONNECT_TIMEOUT: prdata = cfg_q.connect_timeout_ms;
      lrp_pkg::REG_FORGET_FAST:     prdata = {24'd0, cfg_q.forget_fast_after};
      lrp_pkg::REG_RESTART_RADIO:   prdata = {24'd0, cfg_q.restart_radio_every};
      lrp_pkg::REG_AP_RETRY:        prdata = cfg_q.ap_retry_ms;
      lrp_pkg::REG_REBOOT_AFTER:    prdata = cfg_q.reboot_after_ms;
      lrp_pkg::REG_AP_AFTER:        prdata = cfg_q.ap_after_ms;
      default:                      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.connect_timeout_ms  <= 32'd15000;
      cfg_q.forget_fast_after   <= 8'd3;
      cfg_q.restart_radio_every <= 8'd4;
      cfg_q.ap_retry_ms         <= 32'd30000;
      cfg_q.reboot_after_ms     <= 32'd0;
      cfg_q.ap_after_ms         <= 32'd120000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/link_reconnect_policy.sv -----
// ----------------------------------------------------------------------------
// link_reconnect_policy
// Escalation ladder for link recovery: one action per transaction.
// ----------------------------------------------------------------------------
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------------
//  config    | psel/penable/pwrite      | paddr, pwdata, prdata
//  input     | in_valid_i / in_stall_o  | command_i, now_ms_i, link facts
//  output    | out_valid_o / out_stall_i| action_o, offline_time_o,
//            |                          | forget_notice_o
//
//  A reset transaction or a step with the link up goes straight to S_DONE and a
//  take via S_LOST_DIFF; a step with the link down walks S_ATT_DIFF, S_ATT_CMP,
//  S_MOD on a timeout (8-bit remainder for radio restarts) and S_LOST_DIFF onward.
//  Every time difference and time threshold compare goes through one subtractor.
//  Reset clears policy state and loads register defaults.
//  A result waiting on out_stall_i holds; the next transaction is taken meanwhile.
// ----------------------------------------------------------------------------
module link_reconnect_policy #(
  parameter int TIME_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lrp_pkg::ADDR_W-1:0] paddr,
  input  logic [lrp_pkg::DATA_W-1:0] pwdata,
  output logic [lrp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 command_i,
  input  logic [31:0]                now_ms_i,
  input  logic                       link_is_up_i,
  input  logic                       ap_active_i,
  input  logic                       ap_busy_i,
  input  logic                       have_ssid_i,
  input  logic                       refused_new_network_i,
  input  logic                       have_fast_params_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 action_o,
  output logic [31:0]                offline_time_o,
  output logic                       forget_notice_o
);

  localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_ATT_DIFF   = 4'd1;
  localparam logic [3:0] S_ATT_CMP    = 4'd2;
  localparam logic [3:0] S_MOD        = 4'd3;
  localparam logic [3:0] S_LOST_DIFF  = 4'd4;
  localparam logic [3:0] S_REBOOT_CMP = 4'd5;
  localparam logic [3:0] S_AP_CMP     = 4'd6;
  localparam logic [3:0] S_RETRY_DIFF = 4'd7;
  localparam logic [3:0] S_RETRY_CMP  = 4'd8;
  localparam logic [3:0] S_DONE       = 4'd9;

  lrp_pkg::cfg_t        cfg;
  lrp_pkg::mod_status_t mod_status;

  logic [3:0] state_q, state_d;

  // latched transaction
  logic [1:0]           cmd_q, cmd_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic apa_q, apa_d, apb_q, apb_d, ssid_q, ssid_d;
  logic refused_q, refused_d, fastp_q, fastp_d;
  logic [TIME_BITS-1:0] t_q, t_d;

  // policy state
  logic                 link_state_q, link_state_d;
  logic [TIME_BITS-1:0] lost_since_q, lost_since_d;
  logic                 running_q, running_d;
  logic [TIME_BITS-1:0] attempt_start_q, attempt_start_d;
  logic                 attempt_fast_q, attempt_fast_d;
  logic [TIME_BITS-1:0] retry_start_q, retry_start_d;
  logic [31:0]          retry_delay_q, retry_delay_d;
  logic [7:0]           fail_count_q, fail_count_d;
  logic [7:0]           fast_fail_q, fast_fail_d;
  logic                 fast_off_q, fast_off_d;
  logic                 forget_q, forget_d;
  logic                 restart_q, restart_d;

  // result and output register
  logic [2:0]  res_act_q, res_act_d;
  logic [31:0] res_off_q, res_off_d;
  logic        res_notice_q, res_notice_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_act_q;
  logic [31:0] out_off_q;
  logic        out_notice_q;
  logic        out_load;

  logic [CMP_W-1:0] alu_a, alu_b, alu_diff;
  logic             alu_borrow;
  logic             mod_start;
  logic [7:0]       fc_inc, ffc_inc;
  logic [TIME_BITS-1:0] now_in;

  lrp_cfg u_lrp_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lrp_alu #(.Width(CMP_W)) u_lrp_alu (
    .a_i      (alu_a),
    .b_i      (alu_b),
    .diff_o   (alu_diff),
    .borrow_o (alu_borrow)
  );

  lrp_mod u_lrp_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (fc_inc),
    .divisor_i  (cfg.restart_radio_every),
    .status_o   (mod_status)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign now_in     = TIME_BITS'(now_ms_i);
  assign fc_inc     = (fail_count_q == lrp_pkg::SAT_MAX) ? fail_count_q : fail_count_q + 8'd1;
  assign ffc_inc    = (fast_fail_q == lrp_pkg::SAT_MAX) ? fast_fail_q : fast_fail_q + 8'd1;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d         = state_q;
    cmd_d           = cmd_q;
    now_d           = now_q;
    apa_d           = apa_q;
    apb_d           = apb_q;
    ssid_d          = ssid_q;
    refused_d       = refused_q;
    fastp_d         = fastp_q;
    t_d             = t_q;
    link_state_d    = link_state_q;
    lost_since_d    = lost_since_q;
    running_d       = running_q;
    attempt_start_d = attempt_start_q;
    attempt_fast_d  = attempt_fast_q;
    retry_start_d   = retry_start_q;
    retry_delay_d   = retry_delay_q;
    fail_count_d    = fail_count_q;
    fast_fail_d     = fast_fail_q;
    fast_off_d      = fast_off_q;
    forget_d        = forget_q;
    restart_d       = restart_q;
    res_act_d       = res_act_q;
    res_off_d       = res_off_q;
    res_notice_d    = res_notice_q;
    alu_a           = '0;
    alu_b           = '0;
    mod_start       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d        = command_i;
          now_d        = now_in;
          apa_d        = ap_active_i;
          apb_d        = ap_busy_i;
          ssid_d       = have_ssid_i;
          refused_d    = refused_new_network_i;
          fastp_d      = have_fast_params_i;
          res_act_d    = lrp_pkg::ACT_NONE;
          res_off_d    = 32'd0;
          res_notice_d = 1'b0;
          if (command_i == lrp_pkg::CMD_STEP && link_is_up_i) begin
            if (!link_state_q) begin
              link_state_d = 1'b1;
              running_d    = 1'b0;
              restart_d    = 1'b0;
              fail_count_d = 8'd0;
              fast_fail_d  = 8'd0;
              fast_off_d   = 1'b0;
            end
            if (ap_active_i && !ap_busy_i) begin
              res_act_d = lrp_pkg::ACT_STOP_AP;
            end
            state_d = S_DONE;
          end else if (command_i == lrp_pkg::CMD_STEP) begin
            state_d = S_ATT_DIFF;
          end else if (command_i == lrp_pkg::CMD_RESET) begin
            link_state_d    = 1'b0;
            lost_since_d    = now_in;
            running_d       = 1'b0;
            attempt_start_d = now_in;
            attempt_fast_d  = 1'b0;
            retry_start_d   = now_in;
            retry_delay_d   = 32'd0;
            fail_count_d    = 8'd0;
            fast_fail_d     = 8'd0;
            fast_off_d      = 1'b0;
            forget_d        = 1'b0;
            restart_d       = 1'b0;
            state_d         = S_DONE;
          end else begin
            state_d = S_LOST_DIFF;
          end
        end
      end

      S_ATT_DIFF: begin
        alu_a = CMP_W'(now_q);
        alu_b = CMP_W'(attempt_start_q);
        t_d   = alu_diff[TIME_BITS-1:0];
        if (link_state_q) begin
          link_state_d  = 1'b0;
          lost_since_d  = now_q;
          retry_start_d = now_q;
          retry_delay_d = 32'd0;
        end
        state_d = S_ATT_CMP;
      end

      S_ATT_CMP: begin
        alu_a   = CMP_W'(t_q);
        alu_b   = CMP_W'(cfg.connect_timeout_ms);
        state_d = S_LOST_DIFF;
        if (running_q && !alu_borrow) begin
          running_d    = 1'b0;
          fail_count_d = fc_inc;
          if (attempt_fast_q) begin
            fast_fail_d = ffc_inc;
            if (cfg.forget_fast_after != 8'd0 && ffc_inc >= cfg.forget_fast_after
                && !fast_off_q) begin
              fast_off_d = 1'b1;
              forget_d   = 1'b1;
            end
          end
          retry_start_d = now_q;
          retry_delay_d = apa_q ? cfg.ap_retry_ms : 32'd0;
          if (cfg.restart_radio_every != 8'd0) begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        end
      end

      S_MOD: begin
        if (mod_status.done) begin
          if (mod_status.rem_zero) begin
            restart_d = 1'b1;
          end
          state_d = S_LOST_DIFF;
        end
      end

      S_LOST_DIFF: begin
        alu_a = CMP_W'(now_q);
        alu_b = CMP_W'(lost_since_q);
        t_d   = alu_diff[TIME_BITS-1:0];
        res_off_d = link_state_q ? 32'd0 : 32'(alu_diff[TIME_BITS-1:0]);
        if (cmd_q != lrp_pkg::CMD_STEP) begin
          if (cmd_q == lrp_pkg::CMD_TAKE) begin
            res_notice_d = forget_q;
            forget_d     = 1'b0;
          end
          state_d = S_DONE;
        end else if (!ssid_q) begin
          res_act_d = apa_q ? lrp_pkg::ACT_NONE : lrp_pkg::ACT_START_AP;
          state_d   = S_DONE;
        end else begin
          state_d = S_REBOOT_CMP;
        end
      end

      S_REBOOT_CMP: begin
        alu_a = CMP_W'(t_q);
        alu_b = CMP_W'(cfg.reboot_after_ms);
        if (cfg.reboot_after_ms != 32'd0 && !apb_q && !alu_borrow) begin
          res_act_d = lrp_pkg::ACT_REBOOT;
          state_d   = S_DONE;
        end else begin
          state_d = S_AP_CMP;
        end
      end

      S_AP_CMP: begin
        alu_a = CMP_W'(t_q);
        alu_b = CMP_W'(cfg.ap_after_ms);
        if (!apa_q && (refused_q || !alu_borrow)) begin
          res_act_d = lrp_pkg::ACT_START_AP;
          state_d   = S_DONE;
        end else if (running_q) begin
          state_d = S_DONE;
        end else begin
          state_d = S_RETRY_DIFF;
        end
      end

      S_RETRY_DIFF: begin
        alu_a   = CMP_W'(now_q);
        alu_b   = CMP_W'(retry_start_q);
        t_d     = alu_diff[TIME_BITS-1:0];
        state_d = S_RETRY_CMP;
      end

      S_RETRY_CMP: begin
        alu_a   = CMP_W'(t_q);
        alu_b   = CMP_W'(retry_delay_q);
        state_d = S_DONE;
        if (!alu_borrow) begin
          if (restart_q && !apb_q) begin
            restart_d     = 1'b0;
            retry_start_d = now_q;
            retry_delay_d = 32'd0;
            res_act_d     = lrp_pkg::ACT_RESTART_RADIO;
          end else begin
            attempt_fast_d  = fastp_q && !fast_off_q && !fail_count_q[0];
            running_d       = 1'b1;
            attempt_start_d = now_q;
            res_act_d       = (fastp_q && !fast_off_q && !fail_count_q[0]) ?
                              lrp_pkg::ACT_FAST : lrp_pkg::ACT_SCAN;
          end
        end
      end

      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      out_valid_q     <= 1'b0;
      link_state_q    <= 1'b0;
      lost_since_q    <= '0;
      running_q       <= 1'b0;
      attempt_start_q <= '0;
      attempt_fast_q  <= 1'b0;
      retry_start_q   <= '0;
      retry_delay_q   <= 32'd0;
      fail_count_q    <= 8'd0;
      fast_fail_q     <= 8'd0;
      fast_off_q      <= 1'b0;
      forget_q        <= 1'b0;
      restart_q       <= 1'b0;
    end else begin
      state_q         <= state_d;
      out_valid_q     <= out_valid_d;
      link_state_q    <= link_state_d;
      lost_since_q    <= lost_since_d;
      running_q       <= running_d;
      attempt_start_q <= attempt_start_d;
      attempt_fast_q  <= attempt_fast_d;
      retry_start_q   <= retry_start_d;
      retry_delay_q   <= retry_delay_d;
      fail_count_q    <= fail_count_d;
      fast_fail_q     <= fast_fail_d;
      fast_off_q      <= fast_off_d;
      forget_q        <= forget_d;
      restart_q       <= restart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    now_q        <= now_d;
    apa_q        <= apa_d;
    apb_q        <= apb_d;
    ssid_q       <= ssid_d;
    refused_q    <= refused_d;
    fastp_q      <= fastp_d;
    t_q          <= t_d;
    res_act_q    <= res_act_d;
    res_off_q    <= res_off_d;
    res_notice_q <= res_notice_d;
    if (out_load) begin
      out_act_q    <= res_act_q;
      out_off_q    <= res_off_q;
      out_notice_q <= res_notice_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = out_act_q;
  assign offline_time_o  = out_off_q;
  assign forget_notice_o = out_notice_q;

endmodule

// ----- sv/lrp_checker.sv -----
// ----------------------------------------------------------------------------
// lrp_checker
// Port-level checks of the link reconnect policy block.
// ----------------------------------------------------------------------------
module lrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  action_o,
  input logic [31:0] offline_time_o,
  input logic        forget_notice_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(action_o) && $stable(offline_time_o)
      && $stable(forget_notice_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("transaction taken without busy phase");

  a_action_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> action_o <= lrp_pkg::ACT_SCAN)
    else $error("action code out of range");

  a_notice_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && forget_notice_o |-> action_o == lrp_pkg::ACT_NONE)
    else $error("notice alongside an action");

endmodule

bind link_reconnect_policy lrp_checker u_lrp_checker (.*);
